// ===== rtl/bsd_pkg.sv =====
// Shared types and constants for the 24-bit BMP stream decoder.
`timescale 1ns / 1ps

package bsd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE,
        PH_FAILED
    } t_phase;

    typedef enum logic [2:0] {
        ERR_MAGIC  = 3'd0,
        ERR_HEADER = 3'd1,
        ERR_SIZE   = 3'd2,
        ERR_OFFSET = 3'd3,
        ERR_DECL   = 3'd4,
        ERR_TRUNC  = 3'd5,
        ERR_NONE   = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_OK    = 2'd1,
        KIND_FAIL  = 2'd2
    } t_kind;

    localparam int RGBA_W = 32;
    localparam int POS_W  = 15;

    typedef struct packed {
        t_kind              kind;
        logic [RGBA_W-1:0]  pixel_rgba;
        logic [POS_W-1:0]   column;
        logic [POS_W-1:0]   row;
        t_err               error_code;
    } t_result;

    // res0 carries a pixel, res1 the end-of-file status
    typedef struct packed {
        logic    push0;
        t_result res0;
        logic    push1;
        t_result res1;
    } t_core_out;

    // header byte indices at which a little-endian field is complete
    localparam logic [31:0] HDR_IDX_MAGIC    = 32'd1;
    localparam logic [31:0] HDR_IDX_FSIZE    = 32'd5;
    localparam logic [31:0] HDR_IDX_OFFSET   = 32'd13;
    localparam logic [31:0] HDR_IDX_INFO     = 32'd17;
    localparam logic [31:0] HDR_IDX_WIDTH    = 32'd21;
    localparam logic [31:0] HDR_IDX_HEIGHT   = 32'd25;
    localparam logic [31:0] HDR_IDX_BPP      = 32'd29;
    localparam logic [31:0] HDR_IDX_COMPRESS = 32'd33;
    localparam logic [31:0] HDR_IDX_LAST     = 32'd53;

    localparam logic [15:0] MAGIC_BM       = 16'h4D42;
    localparam logic [31:0] INFO_SIZE      = 32'd40;
    localparam logic [15:0] BPP_24         = 16'd24;
    localparam logic [31:0] HDR_MIN_OFFSET = 32'd54;
    localparam logic [7:0]  ALPHA_FF       = 8'hFF;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

endpackage

// ===== rtl/bsd_out_queue.sv =====
// Result queue: takes up to two results a cycle, hands out one while i_ready is high.
`timescale 1ns / 1ps

module bsd_out_queue import bsd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_core_out           i_push,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_head,
    output logic [OQ_CNT_W-1:0] o_count
);

    t_result               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wp, n_wp;
    logic [OQ_PTR_W-1:0]   r_rp, n_rp;
    logic [OQ_CNT_W-1:0]   r_count, n_count;
    logic [OQ_PTR_W-1:0]   w_wp1;
    logic                  w_pop;

    assign w_wp1   = r_wp + OQ_PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    always_comb begin
        n_wp    = r_wp + OQ_PTR_W'(i_push.push0) + OQ_PTR_W'(i_push.push1);
        n_rp    = r_rp + OQ_PTR_W'(w_pop);
        n_count = r_count + OQ_CNT_W'(i_push.push0) + OQ_CNT_W'(i_push.push1)
                  - OQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0 && i_push.push1) begin
            r_mem[r_wp]  <= i_push.res0;
            r_mem[w_wp1] <= i_push.res1;
        end else if (i_push.push0) begin
            r_mem[r_wp] <= i_push.res0;
        end else if (i_push.push1) begin
            r_mem[r_wp] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/bsd_core.sv =====
// Header parsing, checks, pixel assembly and end-of-file status.
`timescale 1ns / 1ps

module bsd_core import bsd_pkg::*; #(
    parameter int MAX_SIDE   = 32768,
    parameter int MAX_PIXELS = 67108864
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    output t_core_out  o_out
);

    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int RSW = SW + 2;
    localparam int DSW = RSW + SW;
    localparam logic [31:0]        MAX_SIDE_U   = 32'(MAX_SIDE);
    localparam logic signed [31:0] NEG_MAX_SIDE = 32'(-MAX_SIDE);
    localparam logic [31:0]        MAX_PIX_U    = 32'(MAX_PIXELS);

    t_phase          r_phase, n_phase;
    logic [31:0]     r_byte_count, n_byte_count;
    logic [31:0]     r_gather, n_gather;
    logic [31:0]     r_declared, n_declared;
    logic [31:0]     r_offset, n_offset;
    logic [SW-1:0]   r_width, n_width;
    logic [SW-1:0]   r_height, n_height;
    logic            r_rev, n_rev;
    t_err            r_fault, n_fault;
    logic [SW-1:0]   r_col, n_col;
    logic [SW-1:0]   r_row, n_row;
    logic [1:0]      r_bip, n_bip;
    logic [7:0]      r_blue, n_blue;
    logic [7:0]      r_green, n_green;
    logic [1:0]      r_pad, n_pad;
    logic [DSW-1:0]  r_data_size;

    logic [31:0]     w_v;
    logic            w_enter_pix;
    logic            w_in_pixels;
    logic            w_hdr_last;
    t_err            w_note;
    t_err            w_fault_after;
    logic            w_neg;
    logic            w_side_ok;
    logic [SW-1:0]   w_mag;
    logic [2*SW-1:0] w_area;
    logic [31:0]     w_room;
    logic [RSW-1:0]  w_row_size;
    logic [DSW-1:0]  w_data_size;
    logic [SW-1:0]   w_col_inc;
    logic [SW-1:0]   w_row_inc;
    logic            w_row_end;
    logic            w_rows_done;
    logic            w_pix_out;
    logic [SW-1:0]   w_dst;
    t_phase          w_phase_step;
    t_err            w_status;

    assign w_v         = {i_data_byte, r_gather[31:8]};
    assign w_enter_pix = (r_phase == PH_SKIP) && (r_byte_count >= r_offset);
    assign w_in_pixels = (r_phase == PH_PIXELS) || w_enter_pix;
    assign w_hdr_last  = (r_byte_count == HDR_IDX_LAST);
    assign w_neg       = w_v[31];
    assign w_side_ok   = w_neg ? ($signed(w_v) >= NEG_MAX_SIDE)
                               : ((w_v != '0) && (w_v <= MAX_SIDE_U));
    assign w_mag       = w_neg ? (SW'(0) - w_v[SW-1:0]) : w_v[SW-1:0];
    assign w_area      = r_width * w_mag;
    assign w_room      = r_declared - r_offset;
    assign w_row_size  = (RSW'({r_width, 1'b0}) + RSW'(r_width) + RSW'(3)) & ~RSW'(3);
    assign w_data_size = w_row_size * r_height;
    assign w_col_inc   = r_col + SW'(1);
    assign w_row_inc   = r_row + SW'(1);
    assign w_dst       = r_rev ? (r_height - SW'(1) - r_row) : r_row;
    assign w_fault_after = (w_note < r_fault) ? w_note : r_fault;

    // header field capture and checks
    always_comb begin
        n_gather   = r_gather;
        n_declared = r_declared;
        n_offset   = r_offset;
        n_width    = r_width;
        n_height   = r_height;
        n_rev      = r_rev;
        w_note     = ERR_NONE;
        if (r_phase == PH_HEADER) begin
            n_gather = w_v;
            unique case (r_byte_count)
                HDR_IDX_MAGIC: begin
                    if (w_v[31:16] != MAGIC_BM) w_note = ERR_MAGIC;
                end
                HDR_IDX_FSIZE:  n_declared = w_v;
                HDR_IDX_OFFSET: n_offset = w_v;
                HDR_IDX_INFO: begin
                    if (w_v != INFO_SIZE) w_note = ERR_HEADER;
                end
                HDR_IDX_WIDTH: begin
                    if (w_v[31] || (w_v == '0) || (w_v > MAX_SIDE_U)) begin
                        w_note  = ERR_SIZE;
                        n_width = '0;
                    end else begin
                        n_width = w_v[SW-1:0];
                    end
                end
                HDR_IDX_HEIGHT: begin
                    n_rev = !w_neg;
                    if (!w_side_ok) begin
                        w_note   = ERR_SIZE;
                        n_height = '0;
                    end else begin
                        n_height = w_mag;
                        if (32'(w_area) > MAX_PIX_U) w_note = ERR_SIZE;
                    end
                end
                HDR_IDX_BPP: begin
                    if (w_v[31:16] != BPP_24) w_note = ERR_HEADER;
                end
                HDR_IDX_COMPRESS: begin
                    if (w_v != '0) w_note = ERR_HEADER;
                end
                HDR_IDX_LAST: begin
                    if (r_offset < HDR_MIN_OFFSET) begin
                        w_note = ERR_OFFSET;
                    end else if ((r_declared != '0) && ((r_offset > r_declared) ||
                                 (64'(r_data_size) > 64'(w_room)))) begin
                        w_note = ERR_DECL;
                    end
                end
                default: ;
            endcase
        end
        n_fault = w_fault_after;
    end

    // pixel assembly and padding skip
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_bip     = r_bip;
        n_blue    = r_blue;
        n_green   = r_green;
        n_pad     = r_pad;
        w_row_end = 1'b0;
        w_pix_out = 1'b0;
        if (w_in_pixels) begin
            if (r_pad != '0) begin
                n_pad     = r_pad - 2'd1;
                w_row_end = (r_pad == 2'd1);
            end else begin
                unique case (r_bip)
                    2'd0: begin
                        n_blue = i_data_byte;
                        n_bip  = 2'd1;
                    end
                    2'd1: begin
                        n_green = i_data_byte;
                        n_bip   = 2'd2;
                    end
                    default: begin
                        w_pix_out = 1'b1;
                        n_bip     = 2'd0;
                        n_col     = w_col_inc;
                        if (w_col_inc >= r_width) begin
                            n_pad     = r_width[1:0];
                            w_row_end = (r_width[1:0] == 2'd0);
                        end
                    end
                endcase
            end
            if (w_row_end) begin
                n_col = '0;
                n_row = w_row_inc;
            end
        end
        w_rows_done = w_row_end && (w_row_inc >= r_height);
    end

    always_comb begin
        w_phase_step = r_phase;
        unique case (r_phase)
            PH_HEADER: begin
                if (w_hdr_last) begin
                    w_phase_step = (w_fault_after != ERR_NONE) ? PH_FAILED : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (w_enter_pix) w_phase_step = w_rows_done ? PH_DONE : PH_PIXELS;
            end
            PH_PIXELS: begin
                if (w_rows_done) w_phase_step = PH_DONE;
            end
            PH_DONE, PH_FAILED: ;
            default: w_phase_step = PH_HEADER;
        endcase
        n_phase = w_phase_step;
    end

    always_comb begin
        n_byte_count = (r_byte_count == '1) ? r_byte_count : r_byte_count + 32'd1;
    end

    // results
    always_comb begin
        priority if (w_fault_after != ERR_NONE) begin
            w_status = w_fault_after;
        end else if (w_phase_step != PH_DONE) begin
            w_status = ERR_TRUNC;
        end else if ((r_declared != '0) &&
                     (({1'b0, r_byte_count} + 33'd1) < {1'b0, r_declared})) begin
            w_status = ERR_TRUNC;
        end else begin
            w_status = ERR_NONE;
        end

        o_out.push0           = i_fire && w_pix_out;
        o_out.res0.kind       = KIND_PIXEL;
        o_out.res0.pixel_rgba = {i_data_byte, r_green, r_blue, ALPHA_FF};
        o_out.res0.column     = POS_W'(r_col);
        o_out.res0.row        = POS_W'(w_dst);
        o_out.res0.error_code = ERR_MAGIC;   // cleared field

        o_out.push1           = i_fire && i_end_of_file;
        o_out.res1.kind       = (w_status == ERR_NONE) ? KIND_OK : KIND_FAIL;
        o_out.res1.pixel_rgba = '0;
        o_out.res1.column     = '0;
        o_out.res1.row        = '0;
        o_out.res1.error_code = (w_status == ERR_NONE) ? ERR_MAGIC : w_status;
    end

    always_ff @(posedge i_clk) begin
        r_data_size <= w_data_size;
    end

    // the last byte of a file returns the decoder to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_end_of_file)) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= '0;
            r_gather     <= '0;
            r_declared   <= '0;
            r_offset     <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_rev        <= 1'b1;
            r_fault      <= ERR_NONE;
            r_col        <= '0;
            r_row        <= '0;
            r_bip        <= '0;
            r_blue       <= '0;
            r_green      <= '0;
            r_pad        <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_gather     <= n_gather;
            r_declared   <= n_declared;
            r_offset     <= n_offset;
            r_width      <= n_width;
            r_height     <= n_height;
            r_rev        <= n_rev;
            r_fault      <= n_fault;
            r_col        <= n_col;
            r_row        <= n_row;
            r_bip        <= n_bip;
            r_blue       <= n_blue;
            r_green      <= n_green;
            r_pad        <= n_pad;
        end
    end

endmodule

// ===== rtl/bmp_24bit_stream_decoder.sv =====
// Top level of the 24-bit BMP stream decoder: input register, core and result queue.
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// input    i_in_valid / o_in_ready   i_data_byte, i_end_of_file
// output   o_out_valid / i_out_ready o_kind, o_pixel_rgba, o_column, o_row, o_error_code
//
// One file byte is taken each cycle while o_in_ready is high. A byte is held
// in the input register, is decoded, and its results enter a four-entry queue;
// the first result is offered once it is written there. The last byte of a
// file can give two results, so the input register only advances while the
// queue has two free entries. Reset is synchronous and needs no clearing pass.

module bmp_24bit_stream_decoder import bsd_pkg::*; #(
    parameter int MAX_SIDE   = 32768,
    parameter int MAX_PIXELS = 67108864
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [RGBA_W-1:0] o_pixel_rgba,
    output logic [POS_W-1:0]  o_column,
    output logic [POS_W-1:0]  o_row,
    output logic [2:0]        o_error_code
);

    localparam logic [OQ_CNT_W-1:0] ROOM_LIMIT = OQ_CNT_W'(OQ_DEPTH - 2);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_eof;
    logic                w_fire;
    t_core_out           w_core;
    t_result             w_head;
    logic [OQ_CNT_W-1:0] w_count;

    assign w_fire     = r_in_valid && (w_count <= ROOM_LIMIT);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    bsd_core #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_PIXELS (MAX_PIXELS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_data_byte   (r_in_byte),
        .i_end_of_file (r_in_eof),
        .o_out         (w_core)
    );

    bsd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_core),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (w_head),
        .o_count (w_count)
    );

    assign o_kind       = w_head.kind;
    assign o_pixel_rgba = w_head.pixel_rgba;
    assign o_column     = w_head.column;
    assign o_row        = w_head.row;
    assign o_error_code = w_head.error_code;

    a_eof_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_eof) |-> w_core.push1)
        else $error("last byte without a status result");

    a_status_only_on_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_in_eof) |-> (!w_core.push1 && !w_core.push1 == 1'b1))
        else $error("status result before the last byte");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_status_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core.push1 |=> o_out_valid)
        else $error("status result not offered");

endmodule
